// ===== rtl/core/ppmv_pkg.sv =====
// Package for the pad pedestal mean/variance block: sizes, codes, the pad
// record layout and shared types. No dependencies.
package ppmv_pkg;

  localparam int SECTORS = 6;
  localparam int COLS    = 92;
  localparam int ROWS    = 90;
  localparam int PADS    = SECTORS * COLS * ROWS;
  localparam int ADDR_W  = $clog2(PADS);

  localparam logic [23:0] CNT_MAX       = 24'hFFFFFF;
  localparam logic [31:0] ONE_HIT_SIGMA = 32'd655;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_RUNAWAY    = 3'd1,
    ST_NOISE      = 3'd2,
    ST_SECTOR_OFF = 3'd3,
    ST_BAD_PAD    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CFG_NOISE_LIMIT    = 3'd0,
    CFG_SECTOR_ENABLE  = 3'd1,
    CFG_REJECT_SIGMAS  = 3'd2,
    CFG_REJECT_MIN_DEV = 3'd3,
    CFG_MIN_EVENTS     = 3'd4
  } cfg_index_t;

  typedef enum logic [1:0] {
    ALU_MUL  = 2'd0,
    ALU_DIV  = 2'd1,
    ALU_SQRT = 2'd2
  } alu_mode_t;

  typedef struct packed {
    logic      start;
    alu_mode_t mode;
  } alu_req_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_ADDR, S_READ, S_LOAD,
    S_SG_CHK, S_SG_MUL, S_SG_MW, S_SG_SQ, S_SG_SW,
    S_DECIDE, S_DIV1, S_DIV1W, S_DIV2, S_DIV2W, S_MUL2, S_MUL2W,
    S_UPD, S_WRITE, S_OUTP, S_DONE
  } state_t;

  typedef struct packed {
    logic        [23:0] acc;
    logic        [23:0] hits;
    logic        [23:0] runs;
    logic signed [31:0] mean;
    logic        [47:0] vacc;
  } pad_rec_t;

  function automatic logic [23:0] sat_inc(input logic [23:0] c);
    return (c == CNT_MAX) ? CNT_MAX : c + 24'd1;
  endfunction

endpackage

// ===== rtl/core/pad_pedestal_mean_variance.sv =====
// Top level of the pad pedestal mean/variance block: sequencer, pad record
// memory and configuration registers. Uses ppmv_pkg and ppmv_alu.
//
// One item is in flight at a time; in_ready is high only while the sequencer
// is idle. After reset a clearing pass writes one pad record per cycle, all
// 49680 of them, before the first item is taken. A read or a noisy hit
// evaluates sigma at most once; an accepted hit takes up to two sigma
// evaluations (each a 32-step multiply and a 32-step root), up to two
// 64-step divides and a 32-step square, and a hit on a disabled sector or
// bad pad uses no arithmetic at all. The arithmetic runs on the shared
// serial arithmetic unit, which retires one bit per cycle. A finished result
// waits in the output register while the next item is taken.
module pad_pedestal_mean_variance (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  input  logic [2:0]         sector,
  input  logic [6:0]         pad_col,
  input  logic [6:0]         pad_row,
  input  logic signed [15:0] charge,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic signed [31:0] pad_mean,
  output logic [31:0]        pad_sigma,
  output logic [23:0]        pad_hits,
  output logic [23:0]        pad_runaways,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import ppmv_pkg::*;

  // Configuration.
  logic signed [15:0] noise_limit;
  logic [5:0]         sector_enable;
  logic [7:0]         reject_sigmas;
  logic [14:0]        reject_min_dev;
  logic [7:0]         min_events;

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_limit    <= 16'sd32767;
      sector_enable  <= 6'd63;
      reject_sigmas  <= 8'd96;
      reject_min_dev <= 15'd32;
      min_events     <= 8'd5;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NOISE_LIMIT:    noise_limit    <= cfg_data;
        CFG_SECTOR_ENABLE:  sector_enable  <= cfg_data[5:0];
        CFG_REJECT_SIGMAS:  reject_sigmas  <= cfg_data[7:0];
        CFG_REJECT_MIN_DEV: reject_min_dev <= cfg_data[14:0];
        CFG_MIN_EVENTS:     min_events     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  state_t state, state_next;

  // Latched item.
  logic               op_r;
  logic [2:0]         sec_r;
  logic [6:0]         col_r, row_r;
  logic signed [15:0] chg_r;

  // Working pad record and scratch.
  logic [ADDR_W-1:0]  addr;
  logic [ADDR_W-1:0]  clr_addr;
  logic [23:0]        n_w, hits_w, runs_w;
  logic signed [31:0] mean_w;
  logic [47:0]        var_w;
  logic [63:0]        var_t;
  logic [32:0]        dev_w;
  logic               d_neg;
  logic [31:0]        ad_w;
  logic [31:0]        sig_w;
  logic               sig_ret_out;
  status_t            st_r;

  // Memory.
  pad_rec_t mem [PADS];
  pad_rec_t rdata;
  pad_rec_t wdata;
  logic     wr_en;
  logic [ADDR_W-1:0] waddr;

  assign wr_en = (state == S_CLEAR) || (state == S_WRITE);
  assign waddr = (state == S_CLEAR) ? clr_addr : addr;
  assign wdata = (state == S_CLEAR) ? pad_rec_t'(0) :
                 pad_rec_t'{acc: n_w, hits: hits_w, runs: runs_w, mean: mean_w, vacc: var_w};

  always_ff @(posedge clk) begin
    if (wr_en) mem[waddr] <= wdata;
    if (state == S_READ) rdata <= mem[addr];
  end

  // Shared unit.
  alu_req_t    alu_req;
  logic [63:0] alu_a;
  logic [31:0] alu_b;
  logic        alu_busy;
  logic [95:0] alu_acc;
  logic [63:0] alu_quo;
  logic [31:0] alu_root;
  logic [31:0] den;

  assign den = {8'b0, n_w} + 32'd1;

  ppmv_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .req  (alu_req),
    .a    (alu_a),
    .b    (alu_b),
    .busy (alu_busy),
    .acc  (alu_acc),
    .quo  (alu_quo),
    .root (alu_root)
  );

  // Address and window checks.
  logic [7:0]  en_ext;
  logic        sec_off, bad_pad;
  logic [9:0]  sc_idx;
  logic [16:0] pad_idx;

  assign en_ext  = {2'b00, sector_enable};
  assign sec_off = ({5'b0, sec_r} >= 8'(SECTORS)) || !en_ext[sec_r];
  assign bad_pad = ({1'b0, col_r} >= 8'(COLS)) || ({1'b0, row_r} >= 8'(ROWS));
  assign sc_idx  = 10'(sec_r * COLS) + {3'b0, col_r};
  assign pad_idx = 17'(sc_idx * ROWS) + {10'b0, row_r};

  // Deviation from the stored mean.
  logic signed [33:0] x_s, m_s, d_s;
  assign x_s = {{6{chg_r[15]}}, chg_r, 12'b0};
  assign m_s = {{2{rdata.mean[31]}}, rdata.mean};
  assign d_s = x_s - m_s;

  // Outlier test.
  logic [39:0] rs_prod;
  logic        runaway;
  assign rs_prod = 40'(reject_sigmas) * 40'(sig_w);
  assign runaway = (n_w > {16'b0, min_events}) &&
                   ({4'b0, dev_w, 4'b0} >= {1'b0, rs_prod} + 41'd16) &&
                   (dev_w > {6'b0, reject_min_dev, 12'b0});

  // Mean update.
  logic signed [33:0] diff_s, mean_n;
  assign diff_s = d_neg ? -$signed({1'b0, alu_quo[32:0]}) : $signed({1'b0, alu_quo[32:0]});
  assign mean_n = {{2{mean_w[31]}}, mean_w} + diff_s;

  logic [63:0] var_sum;
  assign var_sum = var_t + {16'b0, alu_acc[63:16]};

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next  = state;
    alu_req     = '{start: 1'b0, mode: ALU_MUL};
    alu_a       = {16'b0, var_w};
    alu_b       = {8'b0, n_w};
    case (state)
      S_CLEAR:  if (clr_addr == ADDR_W'(PADS - 1)) state_next = S_IDLE;
      S_IDLE:   if (in_valid) state_next = S_ADDR;
      S_ADDR:   state_next = (sec_off || bad_pad) ? S_DONE : S_READ;
      S_READ:   state_next = S_LOAD;
      S_LOAD: begin
        if (op_r || (chg_r >= noise_limit)) state_next = S_OUTP;
        else                                 state_next = S_SG_CHK;
      end
      S_SG_CHK: begin
        if (var_w == '0 || n_w == '0) state_next = sig_ret_out ? S_DONE : S_DECIDE;
        else                          state_next = S_SG_MUL;
      end
      S_SG_MUL: begin
        alu_req    = '{start: 1'b1, mode: ALU_MUL};
        state_next = S_SG_MW;
      end
      S_SG_MW: begin
        if (!alu_busy) begin
          if (alu_acc[71:48] != '0) state_next = sig_ret_out ? S_DONE : S_DECIDE;
          else                      state_next = S_SG_SQ;
        end
      end
      S_SG_SQ: begin
        alu_req    = '{start: 1'b1, mode: ALU_SQRT};
        alu_a      = {alu_acc[47:0], 16'b0};
        alu_b      = '0;
        state_next = S_SG_SW;
      end
      S_SG_SW:  if (!alu_busy) state_next = sig_ret_out ? S_DONE : S_DECIDE;
      S_DECIDE: state_next = runaway ? S_WRITE : S_DIV1;
      S_DIV1: begin
        alu_req    = '{start: 1'b1, mode: ALU_DIV};
        alu_a      = {31'b0, dev_w};
        alu_b      = den;
        state_next = S_DIV1W;
      end
      S_DIV1W:  if (!alu_busy) state_next = (n_w == '0) ? S_UPD : S_DIV2;
      S_DIV2: begin
        alu_req    = '{start: 1'b1, mode: ALU_DIV};
        alu_a      = {15'b0, var_w, 1'b0} + {40'b0, n_w};
        alu_b      = den;
        state_next = S_DIV2W;
      end
      S_DIV2W:  if (!alu_busy) state_next = S_MUL2;
      S_MUL2: begin
        alu_req    = '{start: 1'b1, mode: ALU_MUL};
        alu_a      = {32'b0, ad_w};
        alu_b      = ad_w;
        state_next = S_MUL2W;
      end
      S_MUL2W:  if (!alu_busy) state_next = S_UPD;
      S_UPD:    state_next = S_WRITE;
      S_WRITE:  state_next = S_OUTP;
      S_OUTP:   state_next = (hits_w == 24'd1) ? S_DONE : S_SG_CHK;
      S_DONE:   if (!out_valid || out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else begin
      case (state)
        S_CLEAR: clr_addr <= clr_addr + ADDR_W'(1);
        S_IDLE: begin
          op_r  <= operation;
          sec_r <= sector;
          col_r <= pad_col;
          row_r <= pad_row;
          chg_r <= charge;
        end
        S_ADDR: begin
          addr   <= pad_idx[ADDR_W-1:0];
          st_r   <= sec_off ? ST_SECTOR_OFF : ST_BAD_PAD;
          mean_w <= '0;
          sig_w  <= '0;
          hits_w <= '0;
          runs_w <= '0;
        end
        S_LOAD: begin
          n_w         <= rdata.acc;
          hits_w      <= rdata.hits;
          runs_w      <= rdata.runs;
          mean_w      <= rdata.mean;
          var_w       <= rdata.vacc;
          d_neg       <= d_s[33];
          dev_w       <= d_s[33] ? 33'(-d_s) : d_s[32:0];
          sig_ret_out <= 1'b0;
          if (op_r)                    st_r <= ST_OK;
          else if (chg_r >= noise_limit) st_r <= ST_NOISE;
        end
        S_SG_CHK: if (var_w == '0 || n_w == '0) sig_w <= '0;
        S_SG_MW:  if (!alu_busy && alu_acc[71:48] != '0) sig_w <= 32'hFFFFFFFF;
        S_SG_SW:  if (!alu_busy) sig_w <= alu_root;
        S_DECIDE: begin
          if (runaway) begin
            runs_w <= sat_inc(runs_w);
            hits_w <= sat_inc(hits_w);
            st_r   <= ST_RUNAWAY;
          end
        end
        S_DIV1W: begin
          if (!alu_busy) begin
            mean_w <= mean_n[31:0];
            ad_w   <= alu_quo[31:0];
            if (n_w == '0) var_w <= '0;
          end
        end
        S_DIV2W:  if (!alu_busy) var_t <= {16'b0, var_w} - alu_quo;
        S_MUL2W: begin
          if (!alu_busy) var_w <= (var_sum[63:48] != '0) ? 48'hFFFFFFFFFFFF : var_sum[47:0];
        end
        S_UPD: begin
          n_w    <= sat_inc(n_w);
          hits_w <= sat_inc(hits_w);
          st_r   <= ST_OK;
        end
        S_OUTP: begin
          sig_ret_out <= 1'b1;
          if (hits_w == 24'd1) sig_w <= ONE_HIT_SIGMA;
        end
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || out_ready)) begin
      out_valid    <= 1'b1;
      status       <= st_r;
      pad_mean     <= mean_w;
      pad_sigma    <= sig_w;
      pad_hits     <= hits_w;
      pad_runaways <= runs_w;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    assert property (disable iff (rst) (state == S_CLEAR) |-> !in_ready)
      else $error("item taken during clearing pass");
    assert property (disable iff (rst)
      (out_valid && status == ST_RUNAWAY) |-> (pad_runaways != '0))
      else $error("runaway result with zero runaway count");
    assert property (disable iff (rst)
      (out_valid && (status == ST_SECTOR_OFF || status == ST_BAD_PAD)) |->
      (pad_hits == '0 && pad_mean == '0 && pad_sigma == '0))
      else $error("rejected address reports pad statistics");
    assert property (disable iff (rst) (state == S_WRITE) |=> (state == S_OUTP))
      else $error("write-back not followed by output sigma");
  end

endmodule

// ===== rtl/core/ppmv_alu.sv =====
// Shared serial arithmetic unit: shift-add multiply, restoring divide and
// digit-by-digit square root, one bit (or bit pair) per cycle. Uses ppmv_pkg.
module ppmv_alu (
  input  logic              clk,
  input  logic              rst,
  input  ppmv_pkg::alu_req_t req,
  input  logic [63:0]       a,
  input  logic [31:0]       b,
  output logic              busy,
  output logic [95:0]       acc,
  output logic [63:0]       quo,
  output logic [31:0]       root
);
  import ppmv_pkg::*;

  logic [63:0] opa;
  logic [31:0] opb;
  logic [6:0]  cnt;
  alu_mode_t   mode;
  logic        running;

  logic [33:0] drem;
  logic [35:0] srem;
  logic [35:0] trial;

  assign drem  = {acc[32:0], opa[63]};
  assign srem  = {acc[33:0], opa[63:62]};
  assign trial = {2'b00, opb, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
    end else if (req.start) begin
      running <= 1'b1;
      mode    <= req.mode;
      opa     <= a;
      opb     <= b;
      acc     <= '0;
      cnt     <= (req.mode == ALU_DIV) ? 7'd64 : 7'd32;
    end else if (running) begin
      case (mode)
        ALU_MUL: begin
          acc <= {acc[94:0], 1'b0} + (opb[31] ? {32'b0, opa} : 96'b0);
          opb <= {opb[30:0], 1'b0};
        end
        ALU_DIV: begin
          if (drem >= {2'b00, opb}) begin
            acc <= {62'b0, drem - {2'b00, opb}};
            opa <= {opa[62:0], 1'b1};
          end else begin
            acc <= {62'b0, drem};
            opa <= {opa[62:0], 1'b0};
          end
        end
        ALU_SQRT: begin
          if (srem >= trial) begin
            acc <= {60'b0, srem - trial};
            opb <= {opb[30:0], 1'b1};
          end else begin
            acc <= {60'b0, srem};
            opb <= {opb[30:0], 1'b0};
          end
          opa <= {opa[61:0], 2'b00};
        end
        default: ;
      endcase
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) running <= 1'b0;
    end
  end

  assign busy = running;
  assign quo  = opa;
  assign root = opb;

  always @(posedge clk) begin
    assert property (disable iff (rst) req.start |-> !running)
      else $error("ppmv_alu: start while busy");
  end

endmodule
